[sv/cbm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cbm_pkg;

    localparam int ROM_ADDR_BITS_DEF = 20;
    localparam int PAGE_BYTES        = 32'h2000;
    localparam int ROM_SIZE_RESET    = 32768;

    localparam int OP_W      = 2;
    localparam int ADDR_W    = 16;
    localparam int DATA_W    = 8;
    localparam int TARGET_W  = 3;
    localparam int LOC_W     = 20;
    localparam int ACTION_W  = 3;
    localparam int CART_W    = 3;
    localparam int SIZE_W    = 21;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 21;

    // operations
    localparam logic [OP_W-1:0] OP_MEM_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_MEM_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_IO_WRITE  = 2'd2;

    // targets
    localparam logic [TARGET_W-1:0] TGT_OPEN = 3'd0;
    localparam logic [TARGET_W-1:0] TGT_BOOT = 3'd1;
    localparam logic [TARGET_W-1:0] TGT_EXP  = 3'd2;
    localparam logic [TARGET_W-1:0] TGT_BASE = 3'd3;
    localparam logic [TARGET_W-1:0] TGT_ROM  = 3'd4;
    localparam logic [TARGET_W-1:0] TGT_PIN  = 3'd5;
    localparam logic [TARGET_W-1:0] TGT_SRAM = 3'd6;
    localparam logic [TARGET_W-1:0] TGT_NONE = 3'd7;

    // serial eeprom pin actions
    localparam logic [ACTION_W-1:0] ACT_NONE     = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_CLK_LOW  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_CLK_HIGH = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DAT_LOW  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DAT_HIGH = 3'd4;

    // cartridge types
    localparam logic [CART_W-1:0] CART_PLAIN      = 3'd0;
    localparam logic [CART_W-1:0] CART_HIGH_READ  = 3'd1;
    localparam logic [CART_W-1:0] CART_EEPROM     = 3'd2;
    localparam logic [CART_W-1:0] CART_SAVE_RAM   = 3'd3;
    localparam logic [CART_W-1:0] CART_SLOT_WRITE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CART_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROM_SIZE  = 1'd1;

    // I/O ports
    localparam logic [ADDR_W-1:0] PORT_UPPER_RAM = 16'h0053;
    localparam logic [ADDR_W-1:0] PORT_LOWER_RAM = 16'h007f;

    // state updates produced by one decoded transaction
    typedef struct packed {
        logic       set_hi;     // bank 2 <= hi base, bank 3 <= hi base + 8K
        logic       set_one;    // bank[one_idx] <= one base
        logic [1:0] one_idx;
        logic       set_upper;
        logic       upper_val;
        logic       set_lower;
        logic       lower_val;
    } bank_upd_t;

endpackage

`default_nettype wire

[sv/cartridge_bank_mapper.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake              Payload
// -------   --------------------   ------------------------------------
// input     in_valid / in_ready    operation, address, write_data
// result    out_valid / out_ready  target, location, eeprom_action
// config    cfg_write              cfg_index, cfg_data
//
// One transaction per clock sustained while out_ready stays high; the result is registered
// after input acceptance (input register, then decode into result register).
// Bank and RAM-enable state updates when a transaction leaves the input register,
// so the next transaction decodes against it. Reset loads the plain-cart banks.
// A stalled result holds the input register; in_ready stays high while a free
// slot remains.

module cartridge_bank_mapper
    import cbm_pkg::*;
#(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [DATA_W-1:0]     write_data,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [TARGET_W-1:0]   target,
    output      logic [LOC_W-1:0]      location,
    output      logic [ACTION_W-1:0]   eeprom_action
);

    logic                in_valid_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [DATA_W-1:0]   data_reg;

    logic                out_valid_reg;
    logic [TARGET_W-1:0] target_reg;
    logic [LOC_W-1:0]    location_reg;
    logic [ACTION_W-1:0] action_reg;

    logic                advance;
    logic                in_xfer;

    logic [CART_W-1:0]        cart_type;
    logic [SIZE_W-1:0]        rom_size;
    logic [ROM_ADDR_BITS-1:0] bank [4];
    logic                     upper_on;
    logic                     lower_on;

    logic [TARGET_W-1:0]      dec_tgt;
    logic [LOC_W-1:0]         dec_loc;
    logic [ACTION_W-1:0]      dec_act;
    bank_upd_t                dec_upd;
    logic [ROM_ADDR_BITS-1:0] hi_base;
    logic [ROM_ADDR_BITS-1:0] one_base;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    cbm_bank_regs #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_bank_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .upd       (dec_upd),
        .hi_base   (hi_base),
        .one_base  (one_base),
        .cart_type (cart_type),
        .rom_size  (rom_size),
        .bank      (bank),
        .upper_on  (upper_on),
        .lower_on  (lower_on)
    );

    cbm_decode #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_decode (
        .op        (op_reg),
        .addr      (addr_reg),
        .data      (data_reg),
        .cart_type (cart_type),
        .rom_size  (rom_size),
        .bank      (bank),
        .upper_on  (upper_on),
        .lower_on  (lower_on),
        .tgt       (dec_tgt),
        .loc       (dec_loc),
        .act       (dec_act),
        .upd       (dec_upd),
        .hi_base   (hi_base),
        .one_base  (one_base)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on transfer only
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= operation;
            addr_reg <= address;
            data_reg <= write_data;
        end
        if (advance)
        begin
            target_reg   <= dec_tgt;
            location_reg <= dec_loc;
            action_reg   <= dec_act;
        end
    end

    assign out_valid     = out_valid_reg;
    assign target        = target_reg;
    assign location      = location_reg;
    assign eeprom_action = action_reg;

endmodule

`default_nettype wire

[sv/cbm_bank_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbm_bank_regs
    import cbm_pkg::*;
#(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_write,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                     step,
    input  wire bank_upd_t                upd,
    input  wire logic [ROM_ADDR_BITS-1:0] hi_base,
    input  wire logic [ROM_ADDR_BITS-1:0] one_base,
    output      logic [CART_W-1:0]        cart_type,
    output      logic [SIZE_W-1:0]        rom_size,
    output      logic [ROM_ADDR_BITS-1:0] bank [4],
    output      logic                     upper_on,
    output      logic                     lower_on
);

    localparam logic [ROM_ADDR_BITS-1:0] PAGE = ROM_ADDR_BITS'(PAGE_BYTES);

    logic [CART_W-1:0]        cart_type_reg;
    logic [SIZE_W-1:0]        rom_size_reg;
    logic [ROM_ADDR_BITS-1:0] bank_reg [4];
    logic                     upper_reg;
    logic                     lower_reg;

    logic [CART_W-1:0]        new_type;
    logic [SIZE_W-1:0]        new_size;
    logic [SIZE_W:0]          size_less_2p;
    logic [SIZE_W:0]          size_less_1p;
    logic [ROM_ADDR_BITS-1:0] load_bank [4];

    // reload values for a cart start, from the register values being written
    always_comb
    begin
        new_type = (cfg_index == REG_CART_TYPE) ? cfg_data[CART_W-1:0] : cart_type_reg;
        new_size = (cfg_index == REG_ROM_SIZE) ? cfg_data[SIZE_W-1:0] : rom_size_reg;
        size_less_2p = {1'b0, new_size} - (SIZE_W+1)'(2 * PAGE_BYTES);
        size_less_1p = {1'b0, new_size} - (SIZE_W+1)'(PAGE_BYTES);
        if (new_type == CART_HIGH_READ)
        begin
            load_bank[0] = size_less_2p[ROM_ADDR_BITS-1:0];
            load_bank[1] = size_less_1p[ROM_ADDR_BITS-1:0];
            load_bank[2] = '0;
            load_bank[3] = PAGE;
        end
        else if (new_type == CART_SLOT_WRITE)
        begin
            load_bank[0] = PAGE;
            load_bank[1] = ROM_ADDR_BITS'(2 * PAGE_BYTES);
            load_bank[2] = ROM_ADDR_BITS'(3 * PAGE_BYTES);
            load_bank[3] = '0;
        end
        else
        begin
            load_bank[0] = '0;
            load_bank[1] = PAGE;
            load_bank[2] = ROM_ADDR_BITS'(2 * PAGE_BYTES);
            load_bank[3] = ROM_ADDR_BITS'(3 * PAGE_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cart_type_reg <= CART_PLAIN;
            rom_size_reg  <= SIZE_W'(ROM_SIZE_RESET);
            bank_reg[0]   <= '0;
            bank_reg[1]   <= PAGE;
            bank_reg[2]   <= ROM_ADDR_BITS'(2 * PAGE_BYTES);
            bank_reg[3]   <= ROM_ADDR_BITS'(3 * PAGE_BYTES);
            upper_reg     <= 1'b0;
            lower_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            cart_type_reg <= new_type;
            rom_size_reg  <= new_size;
            bank_reg      <= load_bank;
            upper_reg     <= (new_type == CART_SLOT_WRITE);
            lower_reg     <= 1'b0;
        end
        else if (step)
        begin
            if (upd.set_hi)
            begin
                bank_reg[2] <= hi_base;
                bank_reg[3] <= hi_base + PAGE;
            end
            if (upd.set_one)
            begin
                bank_reg[upd.one_idx] <= one_base;
            end
            if (upd.set_upper)
            begin
                upper_reg <= upd.upper_val;
            end
            if (upd.set_lower)
            begin
                lower_reg <= upd.lower_val;
            end
        end
    end

    assign cart_type = cart_type_reg;
    assign rom_size  = rom_size_reg;
    assign bank      = bank_reg;
    assign upper_on  = upper_reg;
    assign lower_on  = lower_reg;

endmodule

`default_nettype wire

[sv/cbm_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbm_decode
    import cbm_pkg::*;
#(
    parameter int ROM_ADDR_BITS = ROM_ADDR_BITS_DEF
)
(
    input  wire logic [OP_W-1:0]          op,
    input  wire logic [ADDR_W-1:0]        addr,
    input  wire logic [DATA_W-1:0]        data,
    input  wire logic [CART_W-1:0]        cart_type,
    input  wire logic [SIZE_W-1:0]        rom_size,
    input  wire logic [ROM_ADDR_BITS-1:0] bank [4],
    input  wire logic                     upper_on,
    input  wire logic                     lower_on,
    output      logic [TARGET_W-1:0]      tgt,
    output      logic [LOC_W-1:0]         loc,
    output      logic [ACTION_W-1:0]      act,
    output      bank_upd_t                upd,
    output      logic [ROM_ADDR_BITS-1:0] hi_base,
    output      logic [ROM_ADDR_BITS-1:0] one_base
);

    localparam logic [ROM_ADDR_BITS-1:0] PAGE = ROM_ADDR_BITS'(PAGE_BYTES);

    logic [SIZE_W:0]          size_up;
    logic [8:0]               pages;
    logic [ADDR_W-1:0]        mega_mask;
    logic [ADDR_W+13:0]       mega_shift;
    logic [ROM_ADDR_BITS-1:0] mega_base;
    logic                     mega_sel;
    logic [1:0]               slot;
    logic [ROM_ADDR_BITS-1:0] sel_bank;
    logic [ROM_ADDR_BITS-1:0] plain_off;
    logic [SIZE_W:0]          op_off;
    logic [SIZE_W:0]          rom_end;
    logic                     beyond_rom;
    logic [SIZE_W-1:0]        plain_wide;
    logic [SIZE_W-1:0]        op_wide;

    always_comb
    begin
        // 16K bank select on high reads, mask kept in 16 bits
        size_up    = {1'b0, rom_size} + (SIZE_W+1)'(PAGE_BYTES - 1);
        pages      = size_up[SIZE_W:13];
        mega_mask  = ADDR_W'(pages[8:1]) - ADDR_W'(1);
        mega_shift = {addr & mega_mask, 14'b0};
        mega_base  = ROM_ADDR_BITS'(mega_shift);
        mega_sel   = (op == OP_MEM_READ) && (cart_type == CART_HIGH_READ)
                     && (addr >= 16'hffc0);

        // slot-write carts rotate the slot order by one
        slot = (cart_type == CART_SLOT_WRITE) ? (addr[14:13] - 2'd1) : addr[14:13];
        if (mega_sel && slot == 2'd2)
        begin
            sel_bank = mega_base;
        end
        else if (mega_sel && slot == 2'd3)
        begin
            sel_bank = mega_base + PAGE;
        end
        else
        begin
            sel_bank = bank[slot];
        end

        plain_off  = sel_bank + ROM_ADDR_BITS'(addr[12:0]);
        op_off     = (SIZE_W+1)'(sel_bank) + (SIZE_W+1)'(addr[12:0]);
        rom_end    = {1'b0, rom_size} + (SIZE_W+1)'(16'h8000);
        beyond_rom = ((SIZE_W+1)'(addr) >= rom_end);
        plain_wide = SIZE_W'(plain_off);
        op_wide    = SIZE_W'(op_off[ROM_ADDR_BITS-1:0]);
    end

    always_comb
    begin
        tgt      = TGT_NONE;
        loc      = '0;
        act      = ACT_NONE;
        upd      = '0;
        hi_base  = mega_base;
        one_base = ROM_ADDR_BITS'({data[3:0], 13'b0});

        unique case (op)
            OP_MEM_READ:
            begin
                priority if (lower_on && addr < 16'h2000)
                begin
                    tgt = TGT_EXP;
                    loc = LOC_W'(addr);
                end
                else if (addr < 16'h2000)
                begin
                    tgt = TGT_BOOT;
                    loc = LOC_W'(addr);
                end
                else if (upper_on && addr < 16'h8000)
                begin
                    tgt = TGT_EXP;
                    loc = LOC_W'(addr);
                end
                else if (addr < 16'h6000)
                begin
                    tgt = TGT_OPEN;
                end
                else if (addr < 16'h8000)
                begin
                    tgt = TGT_BASE;
                    loc = LOC_W'(addr[9:0]);
                end
                else if (cart_type == CART_EEPROM && addr == 16'hff80)
                begin
                    tgt = TGT_PIN;
                end
                else if (cart_type == CART_SAVE_RAM && addr >= 16'he000)
                begin
                    tgt = TGT_SRAM;
                    loc = LOC_W'(addr[10:0]);
                end
                else if (cart_type == CART_SLOT_WRITE)
                begin
                    if (op_off < (SIZE_W+1)'(rom_size))
                    begin
                        tgt = TGT_ROM;
                        loc = op_wide[LOC_W-1:0];
                    end
                    else
                    begin
                        tgt = TGT_OPEN;
                    end
                end
                else
                begin
                    upd.set_hi = mega_sel;
                    if (beyond_rom)
                    begin
                        tgt = TGT_OPEN;
                    end
                    else
                    begin
                        tgt = TGT_ROM;
                        loc = plain_wide[LOC_W-1:0];
                    end
                end
            end

            OP_MEM_WRITE:
            begin
                priority if (lower_on && addr < 16'h2000)
                begin
                    tgt = TGT_EXP;
                    loc = LOC_W'(addr);
                end
                else if (upper_on && addr >= 16'h2000 && addr < 16'h8000)
                begin
                    tgt = TGT_EXP;
                    loc = LOC_W'(addr);
                end
                else if (addr >= 16'h6000 && addr < 16'h8000)
                begin
                    tgt = TGT_BASE;
                    loc = LOC_W'(addr[9:0]);
                end
                else if (cart_type == CART_EEPROM)
                begin
                    unique case (addr)
                        16'hff90:
                        begin
                            upd.set_hi = 1'b1;
                            hi_base    = ROM_ADDR_BITS'(2 * PAGE_BYTES);
                        end
                        16'hffa0:
                        begin
                            upd.set_hi = 1'b1;
                            hi_base    = ROM_ADDR_BITS'(4 * PAGE_BYTES);
                        end
                        16'hffb0:
                        begin
                            upd.set_hi = 1'b1;
                            hi_base    = ROM_ADDR_BITS'(6 * PAGE_BYTES);
                        end
                        16'hffc0:
                        begin
                            tgt = TGT_PIN;
                            act = ACT_CLK_LOW;
                        end
                        16'hffd0:
                        begin
                            tgt = TGT_PIN;
                            act = ACT_CLK_HIGH;
                        end
                        16'hffe0:
                        begin
                            tgt = TGT_PIN;
                            act = ACT_DAT_LOW;
                        end
                        16'hfff0:
                        begin
                            tgt = TGT_PIN;
                            act = ACT_DAT_HIGH;
                        end
                        default:
                        begin
                            tgt = TGT_NONE;
                        end
                    endcase
                end
                else if (cart_type == CART_SAVE_RAM && addr >= 16'he000)
                begin
                    tgt = TGT_SRAM;
                    loc = LOC_W'(addr[10:0]);
                end
                else if (cart_type == CART_SLOT_WRITE && addr >= 16'hfffc)
                begin
                    upd.set_one = 1'b1;
                    upd.one_idx = addr[1:0];
                end
                else
                begin
                    tgt = TGT_NONE;
                end
            end

            OP_IO_WRITE:
            begin
                // full 16-bit port compare
                if (addr == PORT_UPPER_RAM)
                begin
                    upd.set_upper = 1'b1;
                    upd.upper_val = data[0];
                end
                else if (addr == PORT_LOWER_RAM)
                begin
                    upd.set_lower = 1'b1;
                    upd.lower_val = ~data[1];
                end
            end

            default:
            begin
                tgt = TGT_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

[sv/cbm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module cbm_checker
    import cbm_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic [TARGET_W-1:0] target,
    input wire logic [LOC_W-1:0]    location,
    input wire logic [ACTION_W-1:0] eeprom_action
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(target)
            && $stable(location) && $stable(eeprom_action))
        else $error("result changed while stalled");

    // pin actions only come with the eeprom pin target
    a_action_pin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && eeprom_action != ACT_NONE |-> target == TGT_PIN)
        else $error("eeprom action without pin target");

    a_loc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == TGT_OPEN || target == TGT_PIN || target == TGT_NONE)
            |-> location == '0)
        else $error("nonzero location for a target without memory");

    // base ram is 1K mirrored
    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == TGT_BASE |-> location[LOC_W-1:10] == '0)
        else $error("base ram location out of range");

    a_sram_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target == TGT_SRAM |-> location[LOC_W-1:11] == '0)
        else $error("sram location out of range");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

`default_nettype wire

[sim/cbm_decode_checker.sv]
`timescale 1ns / 1ps

module cbm_decode_checker
    import cbm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_ready,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [ADDR_W-1:0]     address,
    input  wire logic [DATA_W-1:0]     write_data,
    input  wire logic                  out_valid,
    input  wire logic                  out_ready,
    input  wire logic [TARGET_W-1:0]   target,
    input  wire logic [LOC_W-1:0]      location,
    input  wire logic [ACTION_W-1:0]   eeprom_action,
    output int                         mismatches,
    output int                         outstanding,
    output int                         decoded
);

    localparam logic [ADDR_W-1:0] MEGA_SELECT      = 16'hffc0;
    localparam logic [ADDR_W-1:0] EEPROM_PIN_READ  = 16'hff80;
    localparam logic [ADDR_W-1:0] SRAM_BASE        = 16'he000;
    localparam logic [ADDR_W-1:0] SLOT_WRITE_BASE  = 16'hfffc;

    typedef struct packed {
        logic [TARGET_W-1:0] target;
        logic [LOC_W-1:0]    location;
        logic [ACTION_W-1:0] action;
    } decode_t;

    decode_t expected_q[$];

    logic [CART_W-1:0] cart_sel;
    logic [SIZE_W-1:0] rom_bytes;
    logic [LOC_W-1:0]  rom_bank [4];
    logic              upper_on;
    logic              lower_on;

    function automatic decode_t decoded_as(input logic [TARGET_W-1:0] t,
                                           input logic [LOC_W-1:0]    loc,
                                           input logic [ACTION_W-1:0] act);
        decode_t r;
        r.target   = t;
        r.location = loc;
        r.action   = act;
        return r;
    endfunction

    // Any register write restarts the cartridge: banks and RAM flags reload.
    function automatic void load_cart_banks();
        logic [31:0] sz;
        sz = 32'(rom_bytes);
        if (cart_sel == CART_HIGH_READ) begin
            rom_bank[0] = LOC_W'(sz - 2 * PAGE_BYTES);
            rom_bank[1] = LOC_W'(sz - PAGE_BYTES);
            rom_bank[2] = '0;
            rom_bank[3] = LOC_W'(PAGE_BYTES);
        end
        else if (cart_sel == CART_SLOT_WRITE) begin
            rom_bank[0] = LOC_W'(PAGE_BYTES);
            rom_bank[1] = LOC_W'(2 * PAGE_BYTES);
            rom_bank[2] = LOC_W'(3 * PAGE_BYTES);
            rom_bank[3] = '0;
        end
        else begin
            for (int i = 0; i < 4; i++)
                rom_bank[i] = LOC_W'(i * PAGE_BYTES);
        end
        upper_on = (cart_sel == CART_SLOT_WRITE);
        lower_on = 1'b0;
    endfunction

    function automatic decode_t decode_cart_read(input logic [ADDR_W-1:0] a);
        logic [31:0] sz;
        logic [31:0] pages;
        logic [31:0] sel_mask;
        logic [31:0] offset;
        logic [1:0]  page;
        logic [1:0]  slot;
        sz   = 32'(rom_bytes);
        page = a[14:13];
        if (cart_sel == CART_HIGH_READ && a >= MEGA_SELECT) begin
            // mask is taken in 16 bits, so tiny ROMs select with all ones
            pages    = (sz + PAGE_BYTES - 1) / PAGE_BYTES;
            sel_mask = ((pages >> 1) - 1) & 32'hffff;
            rom_bank[2] = LOC_W'((32'(a) & sel_mask) << 14);
            rom_bank[3] = rom_bank[2] + LOC_W'(PAGE_BYTES);
        end
        else if (cart_sel == CART_EEPROM && a == EEPROM_PIN_READ) begin
            return decoded_as(TGT_PIN, '0, ACT_NONE);
        end
        else if (cart_sel == CART_SAVE_RAM && a >= SRAM_BASE) begin
            return decoded_as(TGT_SRAM, LOC_W'(a & 16'h07ff), ACT_NONE);
        end
        else if (cart_sel == CART_SLOT_WRITE) begin
            // window 0x8000 uses bank 3, the rest banks 0..2 upward
            slot   = page - 2'd1;
            offset = 32'(rom_bank[slot]) + 32'(a & 16'h1fff);
            if (offset < sz)
                return decoded_as(TGT_ROM, LOC_W'(offset), ACT_NONE);
            return decoded_as(TGT_OPEN, '0, ACT_NONE);
        end
        if (32'(a) >= sz + 32'h8000)
            return decoded_as(TGT_OPEN, '0, ACT_NONE);
        offset = 32'(rom_bank[page]) + 32'(a & 16'h1fff);
        return decoded_as(TGT_ROM, LOC_W'(offset), ACT_NONE);
    endfunction

    function automatic decode_t decode_mem_write(input logic [ADDR_W-1:0] a,
                                                 input logic [DATA_W-1:0] d);
        decode_t r;
        if (lower_on && a < 16'h2000)
            return decoded_as(TGT_EXP, LOC_W'(a), ACT_NONE);
        if (upper_on && a >= 16'h2000 && a < 16'h8000)
            return decoded_as(TGT_EXP, LOC_W'(a), ACT_NONE);
        if (a >= 16'h6000 && a < 16'h8000)
            return decoded_as(TGT_BASE, LOC_W'(a & 16'h03ff), ACT_NONE);
        r = decoded_as(TGT_NONE, '0, ACT_NONE);
        if (cart_sel == CART_EEPROM) begin
            case (a)
                16'hff90:
                begin
                    rom_bank[2] = LOC_W'(2 * PAGE_BYTES);
                    rom_bank[3] = LOC_W'(3 * PAGE_BYTES);
                end
                16'hffa0:
                begin
                    rom_bank[2] = LOC_W'(4 * PAGE_BYTES);
                    rom_bank[3] = LOC_W'(5 * PAGE_BYTES);
                end
                16'hffb0:
                begin
                    rom_bank[2] = LOC_W'(6 * PAGE_BYTES);
                    rom_bank[3] = LOC_W'(7 * PAGE_BYTES);
                end
                16'hffc0: r = decoded_as(TGT_PIN, '0, ACT_CLK_LOW);
                16'hffd0: r = decoded_as(TGT_PIN, '0, ACT_CLK_HIGH);
                16'hffe0: r = decoded_as(TGT_PIN, '0, ACT_DAT_LOW);
                16'hfff0: r = decoded_as(TGT_PIN, '0, ACT_DAT_HIGH);
                default: ;
            endcase
        end
        else if (cart_sel == CART_SAVE_RAM && a >= SRAM_BASE) begin
            r = decoded_as(TGT_SRAM, LOC_W'(a & 16'h07ff), ACT_NONE);
        end
        else if (cart_sel == CART_SLOT_WRITE && a >= SLOT_WRITE_BASE) begin
            rom_bank[a[1:0]] = LOC_W'({d[3:0], 13'h0});
        end
        return r;
    endfunction

    function automatic decode_t decode_access(input logic [OP_W-1:0]   op,
                                              input logic [ADDR_W-1:0] a,
                                              input logic [DATA_W-1:0] d);
        if (op == OP_MEM_READ) begin
            if (a < 16'h2000)
                return decoded_as(lower_on ? TGT_EXP : TGT_BOOT, LOC_W'(a), ACT_NONE);
            if (upper_on && a < 16'h8000)
                return decoded_as(TGT_EXP, LOC_W'(a), ACT_NONE);
            if (a < 16'h6000)
                return decoded_as(TGT_OPEN, '0, ACT_NONE);
            if (a < 16'h8000)
                return decoded_as(TGT_BASE, LOC_W'(a & 16'h03ff), ACT_NONE);
            return decode_cart_read(a);
        end
        if (op == OP_MEM_WRITE)
            return decode_mem_write(a, d);
        if (op == OP_IO_WRITE) begin
            if (a == PORT_UPPER_RAM)
                upper_on = d[0];
            else if (a == PORT_LOWER_RAM)
                lower_on = ~d[1];
        end
        return decoded_as(TGT_NONE, '0, ACT_NONE);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        decode_t got;
        decode_t want;
        if (!rst_n) begin
            cart_sel  = CART_PLAIN;
            rom_bytes = SIZE_W'(ROM_SIZE_RESET);
            load_cart_banks();
            expected_q.delete();
            mismatches  = 0;
            outstanding = 0;
            decoded     = 0;
        end
        else begin
            if (cfg_write) begin
                if (cfg_index == REG_CART_TYPE)
                    cart_sel = cfg_data[CART_W-1:0];
                else if (cfg_index == REG_ROM_SIZE)
                    rom_bytes = cfg_data[SIZE_W-1:0];
                load_cart_banks();
            end
            // retire results before queuing this edge's transaction
            if (out_valid && out_ready) begin
                got = {target, location, eeprom_action};
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result target=%0d location=0x%05h action=%0d",
                                              got.target, got.location, got.action));
                end
                else begin
                    want = expected_q.pop_front();
                    if (got.target !== want.target)
                        report_mismatch($sformatf("result %0d target: expected %0d, got %0d",
                                                  decoded, want.target, got.target));
                    if (got.location !== want.location)
                        report_mismatch($sformatf("result %0d location: expected 0x%05h, got 0x%05h",
                                                  decoded, want.location, got.location));
                    if (got.action !== want.action)
                        report_mismatch($sformatf("result %0d eeprom_action: expected %0d, got %0d",
                                                  decoded, want.action, got.action));
                    decoded++;
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(decode_access(operation, address, write_data));
            outstanding = expected_q.size();
        end
    end

endmodule

[sim/tb_cartridge_bank_mapper.sv]
`timescale 1ns / 1ps

module tb_cartridge_bank_mapper;
    import cbm_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;
    localparam logic [CART_W-1:0] CART_UNUSED_LO = 3'd5;
    localparam logic [CART_W-1:0] CART_UNUSED_HI = 3'd7;

    localparam int NUM_PHASES      = 18;
    localparam int ACCESSES_PER_PH = 95;
    localparam int HOLD_PHASE      = 9;
    localparam int HOLD_CYCLES     = 200;
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 800000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [OP_W-1:0]       operation;
    logic [ADDR_W-1:0]     address;
    logic [DATA_W-1:0]     write_data;
    logic                  out_valid;
    logic                  out_ready;
    logic [TARGET_W-1:0]   target;
    logic [LOC_W-1:0]      location;
    logic [ACTION_W-1:0]   eeprom_action;

    int mismatches;
    int outstanding;
    int decoded;

    int sent;
    int holdoffs;
    int reg_writes;
    int cycles;
    int phase;
    int stall_left;
    bit sender_idles;
    bit receiver_idles;
    bit hold_req;
    bit hold_now;

    cartridge_bank_mapper i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .address       (address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .target        (target),
        .location      (location),
        .eeprom_action (eeprom_action)
    );

    cbm_decode_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .address       (address),
        .write_data    (write_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .target        (target),
        .location      (location),
        .eeprom_action (eeprom_action),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .decoded       (decoded)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still outstanding",
                     cycles, outstanding);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short idle stretches, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return ADDR_W'($urandom_range(16'hffff));
        if (r < 55)
            return {10'h3ff, 6'($urandom_range(63))};
        if (r < 65)
            return 16'hff80 + ADDR_W'(16 * $urandom_range(7));
        if (r < 75) begin
            case ($urandom_range(15))
                0:  return 16'h0000;
                1:  return 16'h1fff;
                2:  return 16'h2000;
                3:  return 16'h5fff;
                4:  return 16'h6000;
                5:  return 16'h7fff;
                6:  return 16'h8000;
                7:  return 16'h9fff;
                8:  return 16'ha000;
                9:  return 16'hbfff;
                10: return 16'hc000;
                11: return 16'hdfff;
                12: return 16'he000;
                13: return 16'he7ff;
                14: return 16'he800;
                default: return 16'hffbf;
            endcase
        end
        return {1'b1, 15'($urandom_range(16'h7fff))};
    endfunction

    function automatic logic [ADDR_W-1:0] pick_port();
        int r;
        logic [ADDR_W-1:0] port;
        r    = $urandom_range(99);
        port = $urandom_range(1) ? PORT_UPPER_RAM : PORT_LOWER_RAM;
        if (r < 70)
            return port;
        // the full 16-bit port is decoded, so alias the low byte
        if (r < 85)
            return {8'($urandom_range(1, 255)), port[7:0]};
        return ADDR_W'($urandom_range(16'hffff));
    endfunction

    function automatic logic [SIZE_W-1:0] pick_rom_size();
        int pages;
        pages = $urandom_range(128);
        case ($urandom_range(2))
            0:       return SIZE_W'($urandom_range(1048576));
            1:       return SIZE_W'(pages * PAGE_BYTES);
            default: return SIZE_W'(pages * PAGE_BYTES + 1);
        endcase
    endfunction

    task automatic send_access(input logic [OP_W-1:0]   op,
                               input logic [ADDR_W-1:0] addr,
                               input logic [DATA_W-1:0] data);
        int gap;
        gap = (sender_idles && $urandom_range(99) < 25) ? idle_length() : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        address    <= addr;
        write_data <= data;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic random_access();
        int r;
        r = $urandom_range(99);
        if (r < 40)
            send_access(OP_MEM_READ, pick_address(), DATA_W'($urandom_range(255)));
        else if (r < 70)
            send_access(OP_MEM_WRITE, pick_address(), DATA_W'($urandom_range(255)));
        else if (r < 94)
            send_access(OP_IO_WRITE, pick_port(), DATA_W'($urandom_range(255)));
        else
            send_access(OP_UNUSED, ADDR_W'($urandom_range(16'hffff)),
                        DATA_W'($urandom_range(255)));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        reg_writes++;
    endtask

    task automatic configure(input int ph);
        logic [CART_W-1:0] cart;
        logic [SIZE_W-1:0] size;
        size = pick_rom_size();
        case (ph)
            1:  begin cart = CART_HIGH_READ;  size = SIZE_W'(131072);  end
            2:  begin cart = CART_EEPROM;     size = SIZE_W'(65536);   end
            3:  begin cart = CART_SAVE_RAM;   size = SIZE_W'(32768);   end
            4:  begin cart = CART_SLOT_WRITE; size = SIZE_W'(24576);   end
            5:  begin cart = CART_PLAIN;      size = SIZE_W'(0);       end
            6:  begin cart = CART_PLAIN;      size = SIZE_W'(1048576); end
            7:  begin cart = CART_HIGH_READ;  size = SIZE_W'(0);       end
            8:  begin cart = CART_HIGH_READ;  size = SIZE_W'(1048576); end
            9:  cart = CART_HIGH_READ;
            10: cart = CART_EEPROM;
            11: begin cart = CART_SAVE_RAM;   size = SIZE_W'(8191);    end
            12: begin cart = CART_SLOT_WRITE; size = SIZE_W'(0);       end
            13: begin cart = CART_SLOT_WRITE; size = SIZE_W'(1048576); end
            14: cart = CART_SLOT_WRITE;
            15: cart = CART_W'($urandom_range(CART_UNUSED_LO, CART_UNUSED_HI));
            16: cart = CART_SAVE_RAM;
            default: cart = CART_PLAIN;
        endcase
        if ($urandom_range(1)) begin
            write_reg(REG_CART_TYPE, CFG_DATA_W'(cart));
            write_reg(REG_ROM_SIZE, CFG_DATA_W'(size));
        end
        else begin
            write_reg(REG_ROM_SIZE, CFG_DATA_W'(size));
            write_reg(REG_CART_TYPE, CFG_DATA_W'(cart));
        end
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_directed(input int ph);
        case (ph)
            0:
            begin
                send_access(OP_MEM_READ, 16'h0000, 8'h00);
                send_access(OP_MEM_READ, 16'hffff, 8'hff);
                send_access(OP_MEM_READ, 16'h7fff, 8'h00);
                send_access(OP_MEM_READ, 16'h5fff, 8'h00);
                send_access(OP_IO_WRITE, PORT_UPPER_RAM, 8'h01);
                send_access(OP_MEM_READ, 16'h2000, 8'h00);
                send_access(OP_IO_WRITE, PORT_LOWER_RAM, 8'h00);
                send_access(OP_MEM_READ, 16'h1fff, 8'h00);
                send_access(OP_MEM_WRITE, 16'h0000, 8'hff);
                send_access(OP_MEM_WRITE, 16'h2000, 8'h5a);
                send_access(OP_IO_WRITE, PORT_LOWER_RAM, 8'hff);
                send_access(OP_IO_WRITE, PORT_UPPER_RAM, 8'h00);
                send_access(OP_UNUSED, 16'hffff, 8'hff);
                send_access(OP_MEM_WRITE, 16'h6000, 8'h00);
            end
            1:
            begin
                send_access(OP_MEM_READ, 16'hffc3, 8'h00);
                send_access(OP_MEM_READ, 16'hc000, 8'h00);
            end
            2:
            begin
                send_access(OP_MEM_READ, 16'hff80, 8'h00);
                send_access(OP_MEM_WRITE, 16'hff90, 8'h00);
                send_access(OP_MEM_WRITE, 16'hffc0, 8'h00);
                send_access(OP_MEM_WRITE, 16'hfff0, 8'h00);
            end
            3:
            begin
                send_access(OP_MEM_WRITE, 16'he123, 8'ha5);
                send_access(OP_MEM_READ, 16'hffff, 8'h00);
            end
            default:
            begin
                send_access(OP_MEM_WRITE, 16'hfffc, 8'h0f);
                send_access(OP_MEM_READ, 16'h8000, 8'h00);
                send_access(OP_MEM_READ, 16'he000, 8'h00);
            end
        endcase
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever begin
            @(posedge clk);
            hold_now = hold_req;
            @(negedge clk);
            if (hold_now) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holdoffs++;
            end
            else if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (receiver_idles && $urandom_range(99) < 20) begin
                out_ready <= 1'b0;
                stall_left = idle_length() - 1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        operation  = '0;
        address    = '0;
        write_data = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain();
            if (phase > 0)
                configure(phase);
            sender_idles   = (phase % 3 != 2);
            receiver_idles = (phase % 4 != 3);
            if (phase == HOLD_PHASE)
                hold_req = 1'b1;
            if (phase < 5)
                run_directed(phase);
            repeat (ACCESSES_PER_PH) random_access();
        end
        drain();

        $display("Decoded %0d of %0d accesses across %0d mapper settings (%0d register writes)",
                 decoded, sent, NUM_PHASES, reg_writes);
        $display("All cart types, ROM sizes 0 to 1M, %0d long result hold-off(s)", holdoffs);
        if (mismatches == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
